/* design/sfbl_pkg.sv */
// ----------------------------------------------------------------------------
// sfbl_pkg: shared types for the size sorted free block list
// Command and status codes, request and result records, cell links.
// ----------------------------------------------------------------------------
package sfbl_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned COUNT_W     = 5;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_FIT     = 2'd2,
    CMD_LARGEST = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [HANDLE_W-1:0] block_handle;
    logic [SIZE_W-1:0]   block_size;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] found_handle;
    logic [SIZE_W-1:0]   found_size;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  // per-request control broadcast to every cell
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic                fit;
    logic                largest;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic   valid;
    logic   le;
    logic   fit;
    logic   hit;
    entry_t ent;
  } link_t;

endpackage

/* design/sfbl_cell.sv */
// ----------------------------------------------------------------------------
// sfbl_cell: one slot of the sorted free block table
// Holds one block, shifts toward higher slots on insert and lower on remove,
// and flags itself as the selected block for fit and largest requests.
// ----------------------------------------------------------------------------
module sfbl_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfbl_pkg::ctl_t       ctl_i,
  input  sfbl_pkg::link_t      prev_i,
  input  sfbl_pkg::link_t      next_i,
  output sfbl_pkg::link_t      link_o,
  output logic                 sel_o
);

  logic             valid_q, valid_d;
  sfbl_pkg::entry_t ent_q, ent_d;
  logic             sel_q, sel_d;
  logic             le, fit, match, hit;
  logic             load;

  assign le    = valid_q && (ent_q.size <= ctl_i.size);
  assign fit   = valid_q && (ent_q.size >= ctl_i.size);
  assign match = valid_q && (ent_q.handle == ctl_i.handle);
  assign hit   = prev_i.hit || match;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    load    = 1'b0;
    if (ctl_i.ins && !le) begin
      load = 1'b1;
      if (prev_i.le) begin
        valid_d    = 1'b1;
        ent_d.handle = ctl_i.handle;
        ent_d.size   = ctl_i.size;
      end else begin
        valid_d = prev_i.valid;
        ent_d   = prev_i.ent;
      end
    end else if (ctl_i.rem && hit) begin
      load    = 1'b1;
      valid_d = next_i.valid;
      ent_d   = next_i.ent;
    end
  end

  always_comb begin
    sel_d = 1'b0;
    if (ctl_i.fit) begin
      sel_d = fit && !prev_i.fit;
    end else if (ctl_i.largest) begin
      sel_d = valid_q && !next_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.fit || ctl_i.largest || ctl_i.ins || ctl_i.rem) begin
        sel_q <= sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= ent_d;
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.le    = le;
  assign link_o.fit   = fit;
  assign link_o.hit   = hit;
  assign link_o.ent   = ent_q;
  assign sel_o        = sel_q;

endmodule

/* design/size_sorted_free_block_list.sv */
// ----------------------------------------------------------------------------
// size_sorted_free_block_list: free heap blocks kept in ascending size order
// A taken start sets pend_q, and pend_q then sets done_q, the result strobe
// done_o. A new request is taken only while busy is low; busy covers the cycle
// in which the selected cell's block is gathered across the cell row.
// Reset empties the table at once; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module size_sorted_free_block_list #(
  parameter int unsigned ENTRIES = sfbl_pkg::ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sfbl_pkg::req_t req_i,
  output logic           done_o,
  output sfbl_pkg::res_t res_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic                      accept;
  logic [CW-1:0]             count_q, count_d;
  logic                      full;
  logic                      pend_q;
  sfbl_pkg::cmd_e            cmd_q;
  sfbl_pkg::status_e         stat_q, stat_d;
  logic                      done_q;
  sfbl_pkg::res_t            res_q;
  sfbl_pkg::ctl_t            ctl;
  sfbl_pkg::link_t           links [ENTRIES];
  logic [ENTRIES-1:0]        sel;
  logic                      any_sel;
  sfbl_pkg::entry_t          pick;

  assign accept = start && !busy;
  assign busy   = pend_q;
  assign full   = (count_q == CW'(ENTRIES));

  always_comb begin
    ctl.ins     = accept && (req_i.cmd == sfbl_pkg::CMD_INSERT) && !full;
    ctl.rem     = accept && (req_i.cmd == sfbl_pkg::CMD_REMOVE);
    ctl.fit     = accept && (req_i.cmd == sfbl_pkg::CMD_FIT);
    ctl.largest = accept && (req_i.cmd == sfbl_pkg::CMD_LARGEST);
    ctl.handle  = req_i.block_handle;
    ctl.size    = req_i.block_size;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sfbl_pkg::link_t prev_l, next_l;
    if (i == 0) begin : g_first
      always_comb begin
        prev_l       = '0;
        prev_l.le    = 1'b1;
      end
    end else begin : g_mid
      assign prev_l = links[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign next_l = '0;
    end else begin : g_inner
      assign next_l = links[i+1];
    end
    sfbl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (prev_l),
      .next_i (next_l),
      .link_o (links[i]),
      .sel_o  (sel[i])
    );
  end

  always_comb begin
    count_d = count_q;
    stat_d  = sfbl_pkg::ST_OK;
    case (req_i.cmd)
      sfbl_pkg::CMD_INSERT: begin
        if (full) begin
          stat_d = sfbl_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      sfbl_pkg::CMD_REMOVE: begin
        if (links[ENTRIES-1].hit) begin
          count_d = count_q - CW'(1);
        end else begin
          stat_d = sfbl_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        stat_d = sfbl_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    pick    = '0;
    any_sel = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      pick.handle = pick.handle | (links[i].ent.handle & {sfbl_pkg::HANDLE_W{sel[i]}});
      pick.size   = pick.size   | (links[i].ent.size   & {sfbl_pkg::SIZE_W{sel[i]}});
      any_sel     = any_sel | sel[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pend_q <= accept;
      done_q <= pend_q;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.cmd;
      stat_q <= stat_d;
    end
    if (pend_q) begin
      res_q.entry_count <= sfbl_pkg::COUNT_W'(count_q);
      if (cmd_q == sfbl_pkg::CMD_FIT || cmd_q == sfbl_pkg::CMD_LARGEST) begin
        res_q.status       <= any_sel ? sfbl_pkg::ST_OK : sfbl_pkg::ST_NOTFOUND;
        res_q.found_handle <= pick.handle;
        res_q.found_size   <= pick.size;
      end else begin
        res_q.status       <= stat_q;
        res_q.found_handle <= '0;
        res_q.found_size   <= '0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
